>>> sv/slpc_pkg.sv
package slpc_pkg;

  localparam int unsigned BlockCount       = 16;
  localparam int unsigned PatternsPerBlock = 8;

  // block and pattern fields of a serial word
  localparam int unsigned BlkW     = 4;
  localparam int unsigned PatW     = 3;
  localparam int unsigned AddrW    = BlkW + PatW;
  localparam int unsigned RamDepth = 2 ** AddrW;

  localparam int unsigned SelectBit = 7;

  typedef logic [BlkW-1:0]  blk_t;
  typedef logic [PatW-1:0]  pat_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic [7:0] high;
    logic [7:0] low;
  } pair_t;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    pair_t wr_data;
  } ram_req_t;

  function automatic logic blk_in_range(blk_t b);
    return {1'b0, b} < (BlkW + 1)'(BlockCount);
  endfunction

  function automatic logic pat_in_range(pat_t p);
    return {1'b0, p} < (PatW + 1)'(PatternsPerBlock);
  endfunction

  // power-up contents: byte k of a block row holds k mod 8
  function automatic pair_t reset_pair(pat_t p);
    pair_t r;
    r.low  = {5'b0, p[1:0], 1'b0};
    r.high = {5'b0, p[1:0], 1'b1};
    return r;
  endfunction

endpackage

>>> sv/slpc_channels.sv
interface slpc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  logic [3:0] block_select;
  logic       preview_held;

  modport source (output valid, operation, rx_byte, block_select, preview_held,
                  input ready);
  modport sink   (input valid, operation, rx_byte, block_select, preview_held,
                  output ready);
endinterface

interface slpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_low;
  logic [7:0] drive_high;
  logic       drive_update;

  modport source (output valid, drive_low, drive_high, drive_update, input ready);
  modport sink   (input valid, drive_low, drive_high, drive_update, output ready);
endinterface

>>> sv/slpc_pattern_ram.sv
module slpc_pattern_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slpc_pkg::ram_req_t req_i,
  output slpc_pkg::pair_t   rdata_o
);

  slpc_pkg::pair_t                        mem_q [slpc_pkg::RamDepth];
  logic [slpc_pkg::RamDepth-1:0]          written_q;
  logic                                   hit_q;
  slpc_pkg::pat_t                         pat_q;
  slpc_pkg::pair_t                        raw_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      raw_q <= mem_q[req_i.rd_addr];
      pat_q <= req_i.rd_addr[slpc_pkg::PatW-1:0];
    end
  end

  // entries never written read back as their power-up contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      hit_q     <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        hit_q <= written_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = hit_q ? raw_q : slpc_pkg::reset_pair(pat_q);

endmodule

>>> sv/serial_led_pattern_controller.sv
// Path: stage 1 holds a word while the pattern RAM, with one read and one write
// port, serves it at most once; the output register then takes the result.
// Throughput: one word per cycle unless the output stalls.
// Reset: control, phase and selection state clear at once; the pattern table
// reads as its power-up contents through per-entry written flags, no clearing pass.
module serial_led_pattern_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  slpc_in_if.sink    in_i,
  slpc_out_if.source out_o
);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhData0  = 2'd1,
    PhData1  = 2'd2
  } phase_e;

  phase_e                  phase_q;
  logic                    sel_en_q;
  slpc_pkg::blk_t          pend_blk_q;
  slpc_pkg::pat_t          pend_pat_q;
  logic [7:0]              first_q;
  slpc_pkg::pat_t          step_q;
  slpc_pkg::pat_t          cur_pat_q [slpc_pkg::BlockCount];

  logic                    s1_vld_q, s1_drive_q, s1_read_q;
  logic                    out_vld_q, out_upd_q;
  slpc_pkg::pair_t         out_pair_q, held_q;

  logic                    acc, s1_adv, is_select, is_program;
  logic                    rd_need, drive;
  slpc_pkg::blk_t          rx_blk;
  slpc_pkg::pat_t          rx_pat, tick_pat;
  slpc_pkg::ram_req_t      ram_req;
  slpc_pkg::pair_t         ram_rdata, next_pair;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign acc        = in_i.valid && in_i.ready;

  assign rx_blk     = in_i.rx_byte[slpc_pkg::PatW +: slpc_pkg::BlkW];
  assign rx_pat     = in_i.rx_byte[slpc_pkg::PatW-1:0];
  assign is_select  = !in_i.operation && in_i.rx_byte[slpc_pkg::SelectBit] && sel_en_q;
  assign is_program = !in_i.operation && !is_select;

  always_comb begin
    tick_pat = step_q;
    if (!in_i.preview_held) begin
      tick_pat = slpc_pkg::blk_in_range(in_i.block_select) ?
                 cur_pat_q[in_i.block_select] : '0;
    end
  end

  always_comb begin
    drive   = 1'b0;
    rd_need = 1'b0;
    if (in_i.operation) begin
      drive   = 1'b1;
      rd_need = slpc_pkg::blk_in_range(in_i.block_select) &&
                slpc_pkg::pat_in_range(tick_pat);
    end else if (is_select) begin
      drive   = slpc_pkg::blk_in_range(rx_blk) && slpc_pkg::pat_in_range(rx_pat);
      rd_need = drive;
    end
  end

  always_comb begin
    ram_req.rd_en   = acc && rd_need;
    ram_req.rd_addr = in_i.operation ? {in_i.block_select, tick_pat} : {rx_blk, rx_pat};
    ram_req.wr_en   = acc && is_program && (phase_q == PhData1) &&
                      slpc_pkg::blk_in_range(pend_blk_q) &&
                      slpc_pkg::pat_in_range(pend_pat_q);
    ram_req.wr_addr = {pend_blk_q, pend_pat_q};
    ram_req.wr_data = '{high: in_i.rx_byte, low: first_q};
  end

  slpc_pattern_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // out-of-range tick drives zero; a word that does not drive keeps the held bytes
  always_comb begin
    if (s1_read_q) begin
      next_pair = ram_rdata;
    end else if (s1_drive_q) begin
      next_pair = '0;
    end else begin
      next_pair = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      sel_en_q   <= 1'b1;
      pend_blk_q <= '0;
      pend_pat_q <= '0;
      first_q    <= '0;
      step_q     <= '0;
      for (int i = 0; i < slpc_pkg::BlockCount; i++) begin
        cur_pat_q[i] <= '0;
      end
    end else if (acc) begin
      if (in_i.operation) begin
        if (in_i.preview_held) begin
          step_q <= (step_q == slpc_pkg::PatW'(slpc_pkg::PatternsPerBlock - 1)) ?
                    '0 : step_q + 1'b1;
        end else begin
          step_q <= '0;
        end
      end else if (is_select) begin
        if (drive) begin
          cur_pat_q[rx_blk] <= rx_pat;
        end
      end else begin
        if (sel_en_q) begin
          sel_en_q   <= 1'b0;
          pend_blk_q <= rx_blk;
          pend_pat_q <= rx_pat;
        end
        case (phase_q)
          PhHeader: phase_q <= PhData0;
          PhData0: begin
            first_q <= in_i.rx_byte;
            phase_q <= PhData1;
          end
          PhData1: begin
            sel_en_q <= 1'b1;
            phase_q  <= PhHeader;
          end
          default: phase_q <= PhHeader;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_drive_q <= 1'b0;
      s1_read_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      out_upd_q  <= 1'b0;
      out_pair_q <= '0;
      held_q     <= '0;
    end else begin
      if (acc) begin
        s1_vld_q   <= 1'b1;
        s1_drive_q <= drive;
        s1_read_q  <= rd_need;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q  <= 1'b1;
        out_pair_q <= next_pair;
        out_upd_q  <= s1_drive_q;
        held_q     <= next_pair;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.drive_low    = out_pair_q.low;
  assign out_o.drive_high   = out_pair_q.high;
  assign out_o.drive_update = out_upd_q;

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WordTarget = 1150;
  localparam int unsigned LongHold   = 250;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RowBytes   = 2 * slpc_pkg::PatternsPerBlock;

  typedef enum logic {
    OP_SERIAL = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_HEADER      = 2'd0,
    PH_FIRST_DATA  = 2'd1,
    PH_SECOND_DATA = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] low;
    logic [7:0] high;
    logic       update;
  } drive_t;

  class drive_scoreboard;
    logic [7:0]      pattern_bytes [slpc_pkg::BlockCount][RowBytes];
    slpc_pkg::pat_t  current_pat [slpc_pkg::BlockCount];
    logic            select_on;
    phase_e          phase;
    slpc_pkg::blk_t  pend_blk;
    slpc_pkg::pat_t  pend_pat;
    logic [7:0]      first_byte;
    int unsigned     preview_idx;
    logic [7:0]      held_low;
    logic [7:0]      held_high;
    drive_t          expected_drives[$];
    int unsigned     errors, checked, table_writes, selects, ticks;

    function new();
      for (int b = 0; b < slpc_pkg::BlockCount; b++) begin
        current_pat[b] = '0;
        for (int k = 0; k < RowBytes; k++) pattern_bytes[b][k] = 8'(k & 7);
      end
      select_on   = 1'b1;
      phase       = PH_HEADER;
      pend_blk    = '0;
      pend_pat    = '0;
      first_byte  = '0;
      preview_idx = 0;
      held_low    = '0;
      held_high   = '0;
      errors      = 0;
      checked     = 0;
      table_writes = 0;
      selects     = 0;
      ticks       = 0;
    endfunction

    function void load_drive(int unsigned b, int unsigned p);
      if (b < slpc_pkg::BlockCount && p < slpc_pkg::PatternsPerBlock) begin
        held_low  = pattern_bytes[b][2*p];
        held_high = pattern_bytes[b][2*p+1];
      end else begin
        held_low  = '0;
        held_high = '0;
      end
    endfunction

    function int unsigned pending();
      return expected_drives.size();
    endfunction

    // one accepted input word always yields exactly one drive result
    function void note_word(op_e op, logic [7:0] rx, slpc_pkg::blk_t sel, logic prev);
      drive_t         res;
      slpc_pkg::blk_t b;
      slpc_pkg::pat_t p;
      res.update = 1'b0;
      b = rx[6:3];
      p = rx[2:0];
      if (op == OP_SERIAL) begin
        if (rx[slpc_pkg::SelectBit] && select_on) begin
          if (b < slpc_pkg::BlockCount && p < slpc_pkg::PatternsPerBlock) begin
            current_pat[b] = p;
            load_drive(b, p);
            res.update = 1'b1;
            selects++;
          end
        end else begin
          if (select_on) begin
            select_on = 1'b0;
            pend_blk  = b;
            pend_pat  = p;
          end
          case (phase)
            PH_FIRST_DATA: first_byte = rx;
            PH_SECOND_DATA: begin
              if (pend_blk < slpc_pkg::BlockCount &&
                  pend_pat < slpc_pkg::PatternsPerBlock) begin
                pattern_bytes[pend_blk][2*pend_pat]   = first_byte;
                pattern_bytes[pend_blk][2*pend_pat+1] = rx;
                table_writes++;
              end
              select_on = 1'b1;
            end
            default: ;
          endcase
          phase = (phase == PH_SECOND_DATA) ? PH_HEADER : phase_e'(phase + 2'd1);
        end
      end else begin
        if (prev) begin
          load_drive(sel, preview_idx);
          preview_idx = (preview_idx + 1 >= slpc_pkg::PatternsPerBlock) ?
                        0 : preview_idx + 1;
        end else begin
          load_drive(sel, (sel < slpc_pkg::BlockCount) ? current_pat[sel] : 0);
          preview_idx = 0;
        end
        res.update = 1'b1;
        ticks++;
      end
      res.low  = held_low;
      res.high = held_high;
      expected_drives.push_back(res);
    endfunction

    function void check_drive(logic [7:0] low, logic [7:0] high, logic update);
      drive_t exp_d;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive word low=%h high=%h update=%b",
                 $time, low, high, update);
        return;
      end
      exp_d = expected_drives.pop_front();
      checked++;
      if (low !== exp_d.low) begin
        errors++;
        $display("%0t: drive_low mismatch, expected %h, got %h", $time, exp_d.low, low);
      end
      if (high !== exp_d.high) begin
        errors++;
        $display("%0t: drive_high mismatch, expected %h, got %h", $time, exp_d.high, high);
      end
      if (update !== exp_d.update) begin
        errors++;
        $display("%0t: drive_update mismatch, expected %b, got %b",
                 $time, exp_d.update, update);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  slpc_in_if  in_if ();
  slpc_out_if out_if ();

  serial_led_pattern_controller DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  drive_scoreboard sb = new();

  int unsigned cycles        = 0;
  int unsigned words_sent    = 0;
  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  logic        long_hold_req = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 15) : $urandom_range(3, 1);
  endfunction

  function automatic slpc_pkg::blk_t pick_block();
    return $urandom_range(1, 0) ? slpc_pkg::blk_t'($urandom_range(3, 0)) :
                                  slpc_pkg::blk_t'($urandom_range(15, 0));
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial out_if.ready = 1'b0;
  always begin
    @(posedge clk_i);
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (long_hold_req) begin
      out_if.ready <= 1'b0;
      repeat (LongHold) @(posedge clk_i);
      long_hold_req = 1'b0;
    end else if ($urandom_range(99, 0) < out_stall_pct) begin
      out_if.ready <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_drive(out_if.drive_low, out_if.drive_high, out_if.drive_update);
  end

  task automatic send_word(input op_e op, input logic [7:0] rx, input slpc_pkg::blk_t sel,
                           input logic prev);
    if ($urandom_range(99, 0) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.rx_byte      <= rx;
    in_if.block_select <= sel;
    in_if.preview_held <= prev;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(op, rx, sel, prev);
    words_sent++;
  endtask

  // header word then two data words; block_select and preview are don't-care here
  task automatic program_pattern(input logic [7:0] header, input logic [7:0] d0,
                                 input logic [7:0] d1);
    send_word(OP_SERIAL, header, slpc_pkg::blk_t'($urandom_range(15, 0)),
              1'($urandom_range(1, 0)));
    send_word(OP_SERIAL, d0, slpc_pkg::blk_t'($urandom_range(15, 0)),
              1'($urandom_range(1, 0)));
    send_word(OP_SERIAL, d1, slpc_pkg::blk_t'($urandom_range(15, 0)),
              1'($urandom_range(1, 0)));
  endtask

  initial begin
    int unsigned    next_mix;
    int unsigned    kind;
    int unsigned    run_len;
    int unsigned    prev_mode;
    slpc_pkg::blk_t blk;
    logic           hold_done;
    logic           drain_done;

    next_mix   = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_SERIAL;
    in_if.rx_byte      = '0;
    in_if.block_select = '0;
    in_if.preview_held = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: power-up table, select extremes, program with select-like data, preview wrap
    send_word(OP_TICK, 8'h00, 4'd0, 1'b0);
    send_word(OP_TICK, 8'hFF, 4'd15, 1'b0);
    send_word(OP_SERIAL, 8'h80, 4'd0, 1'b0);
    send_word(OP_SERIAL, 8'hFF, 4'd15, 1'b1);
    send_word(OP_TICK, 8'h00, 4'd15, 1'b0);
    program_pattern(8'h7F, 8'hFF, 8'h80);
    send_word(OP_TICK, 8'hA5, 4'd15, 1'b0);
    program_pattern(8'h00, 8'h00, 8'hA5);
    repeat (9) send_word(OP_TICK, 8'h00, 4'd15, 1'b1);
    send_word(OP_TICK, 8'h00, 4'd15, 1'b0);
    send_word(OP_TICK, 8'h00, 4'd0, 1'b1);
    program_pattern(8'h3A, 8'h81, 8'hC3);
    send_word(OP_SERIAL, 8'hBA, 4'd0, 1'b0);

    while (words_sent < WordTarget) begin
      if (words_sent >= next_mix) begin
        case ($urandom_range(2, 0))
          0: in_gap_pct = 0;
          1: in_gap_pct = 15;
          default: in_gap_pct = 40;
        endcase
        case ($urandom_range(2, 0))
          0: out_stall_pct = 0;
          1: out_stall_pct = 20;
          default: out_stall_pct = 50;
        endcase
        next_mix += 120;
      end
      if (!hold_done && words_sent >= 400) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!drain_done && words_sent >= 800) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
        drain_done = 1'b1;
      end

      kind = $urandom_range(99, 0);
      if (kind < 35) begin
        send_word(OP_SERIAL, {1'b1, pick_block(), 3'($urandom_range(7, 0))},
                  slpc_pkg::blk_t'($urandom_range(15, 0)), 1'($urandom_range(1, 0)));
      end else if (kind < 60) begin
        program_pattern({1'b0, pick_block(), 3'($urandom_range(7, 0))},
                        8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
      end else if (kind < 88) begin
        run_len   = $urandom_range(10, 1);
        prev_mode = $urandom_range(2, 0);
        blk       = pick_block();
        repeat (run_len)
          send_word(OP_TICK, 8'($urandom_range(255, 0)), blk,
                    (prev_mode == 2) ? 1'($urandom_range(1, 0)) : 1'(prev_mode));
      end else begin
        repeat ($urandom_range(3, 1))
          send_word(op_e'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                    slpc_pkg::blk_t'($urandom_range(15, 0)), 1'($urandom_range(1, 0)));
      end
    end

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);

    $display("%0d words sent: %0d panel ticks, %0d pattern selects, %0d table writes",
             words_sent, sb.ticks, sb.selects, sb.table_writes);
    $display("%0d drive words checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
